[src/tdlm_pkg.sv]
// Shared constants, field widths and glyph bitmaps for the two-digit LED matrix renderer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tdlm_pkg;

    localparam int NUMBER_W = 7;
    localparam int POS_W    = 10;
    localparam int LEVEL_W  = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int DIGIT_W  = 4;

    localparam int GLYPH_ROWS = 18;
    localparam int GLYPH_COLS = 10;
    localparam int GR_W       = 5;
    localparam int GC_W       = 4;

    localparam logic [ROW_W-1:0]    GLYPH_TOP    = ROW_W'(7);
    localparam logic [COL_W-1:0]    SHIFT_SINGLE = COL_W'(11);
    localparam logic [COL_W-1:0]    SHIFT_TENS   = COL_W'(18);
    localparam logic [COL_W-1:0]    SHIFT_UNITS  = COL_W'(4);
    localparam logic [NUMBER_W-1:0] NUMBER_MAX   = NUMBER_W'(99);
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = LEVEL_W'(12);

    typedef logic [GLYPH_COLS-1:0] glyph_row_t;

    // One column mask per glyph row; bit c is glyph column c.
    localparam glyph_row_t GLYPH_MAP [10][GLYPH_ROWS] = '{
        '{10'h3FF, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201,
          10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h3FF},
        '{10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030,
          10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030, 10'h030},
        '{10'h1FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001,
          10'h3FF, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h3FE},
        '{10'h1FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001,
          10'h1FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h1FF},
        '{10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201,
          10'h3FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001},
        '{10'h3FE, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200,
          10'h3FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h3FF},
        '{10'h3FE, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200, 10'h200,
          10'h3FF, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h3FF},
        '{10'h3FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001,
          10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001},
        '{10'h3FF, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201,
          10'h3FF, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h3FF},
        '{10'h3FF, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201, 10'h201,
          10'h3FF, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001, 10'h001}
    };

endpackage

`default_nettype wire

[src/tdlm_in_if.sv]
// Request channel carrying the number to show and one strip position.
// Depends on tdlm_pkg for the field widths.
`default_nettype none

interface tdlm_in_if import tdlm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] shown_number;
    logic [POS_W-1:0]    strip_position;

    modport source (output valid, output shown_number, output strip_position, input ready);
    modport sink   (input valid, input shown_number, input strip_position, output ready);
endinterface

`default_nettype wire

[src/tdlm_out_if.sv]
// Result channel carrying the lit flag and the three colour bytes of one LED.
// Depends on tdlm_pkg for the field widths.
`default_nettype none

interface tdlm_out_if import tdlm_pkg::*;;
    logic               valid;
    logic               ready;
    logic               lit;
    logic [LEVEL_W-1:0] green_byte;
    logic [LEVEL_W-1:0] blue_byte;
    logic [LEVEL_W-1:0] red_byte;

    modport source (output valid, output lit, output green_byte, output blue_byte,
                    output red_byte, input ready);
    modport sink   (input valid, input lit, input green_byte, input blue_byte,
                    input red_byte, output ready);
endinterface

`default_nettype wire

[src/tdlm_cfg_if.sv]
// Configuration write channel carrying the pixel level.
// Depends on tdlm_pkg for the field width.
`default_nettype none

interface tdlm_cfg_if import tdlm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pixel_level;

    modport source (output valid, output pixel_level, input ready);
    modport sink   (input valid, input pixel_level, output ready);
endinterface

`default_nettype wire

[src/tdlm_glyph.sv]
// Maps a strip position to panel row and column and tests it against the digit glyphs.
// Depends on tdlm_pkg for the glyph bitmaps and placement constants.
`default_nettype none

module tdlm_glyph
    import tdlm_pkg::*;
(
    input  wire logic [NUMBER_W-1:0] shown_number,
    input  wire logic [POS_W-1:0]    strip_position,
    output logic                     lit
);

    logic [NUMBER_W-1:0] number;
    logic [1:0]          band;
    logic [COL_W-1:0]    group;
    logic [2:0]          off;
    logic [COL_W-1:0]    col;
    logic [2:0]          inner;
    logic [ROW_W-1:0]    row;
    logic [14:0]         tens_prod;
    logic [DIGIT_W-1:0]  tens;
    logic [NUMBER_W-1:0] tens_times_ten;
    logic [DIGIT_W-1:0]  units;

    // True when (row, col) falls on a set pixel of the digit placed at the given shift.
    function automatic logic glyph_hit(
        input logic [DIGIT_W-1:0] digit,
        input logic [COL_W-1:0]   shift,
        input logic [ROW_W-1:0]   r,
        input logic [COL_W-1:0]   c
    );
        logic [ROW_W:0] gr;
        logic [COL_W:0] gc;
        logic           inside_box;
        gr = {1'b0, r} - {1'b0, GLYPH_TOP};
        gc = {1'b0, c} - {1'b0, shift};
        inside_box = !gr[ROW_W] && (gr[ROW_W-1:0] < GR_W'(GLYPH_ROWS))
                  && !gc[COL_W] && (gc[COL_W-1:0] < COL_W'(GLYPH_COLS));
        return inside_box
            && GLYPH_MAP[digit][gr[GR_W-1:0]][gc[GC_W-1:0]];
    endfunction

    always_comb
    begin
        number = (shown_number > NUMBER_MAX) ? NUMBER_MAX : shown_number;

        // Odd bands run columns upward, even bands downward; the row inside
        // a band flips with column parity.
        band  = strip_position[9:8];
        group = strip_position[7:3];
        off   = strip_position[2:0];
        col   = band[0] ? group : ~group;
        inner = col[0] ? off : ~off;
        row   = {~band, inner};

        // Divide by ten through the reciprocal 205/2048, exact below 100.
        tens_prod      = 15'(number) * 15'd205;
        tens           = tens_prod[14:11];
        tens_times_ten = NUMBER_W'(tens) * NUMBER_W'(10);
        units          = DIGIT_W'(number - tens_times_ten);

        if (number < NUMBER_W'(10))
        begin
            lit = glyph_hit(DIGIT_W'(number), SHIFT_SINGLE, row, col);
        end
        else
        begin
            lit = glyph_hit(tens, SHIFT_TENS, row, col)
               || glyph_hit(units, SHIFT_UNITS, row, col);
        end
    end

endmodule

`default_nettype wire

[src/two_digit_led_matrix_renderer_unit.sv]
// Top level of the two-digit LED matrix renderer: input register, glyph test, result register.
// Depends on tdlm_pkg, the three channel interfaces and tdlm_glyph.
`default_nettype none

// Channel     | Role | Payload                                       | Handshake
// ------------+------+-----------------------------------------------+-------------
// number_pos  | sink | shown_number[6:0], strip_position[9:0]        | valid/ready
// led         | src  | lit, green_byte, blue_byte, red_byte [7:0]    | valid/ready
// cfg         | sink | pixel_level[7:0]                              | valid/ready
//
// Each request passes through two register stages: the input register, then the result
// register after the glyph lookup. A result is presented once its request has moved on from
// the input register into the result register.
// One request is taken every cycle while the result side keeps up; each stage holds its
// contents when the stage after it is full and stalled, and ready goes low only when both are.
// Reset empties both stages and sets the pixel level to 12. The configuration port is always
// ready; the level is sampled when the result register loads.

module two_digit_led_matrix_renderer_unit
    import tdlm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tdlm_in_if.sink    number_pos,
    tdlm_cfg_if.sink   cfg,
    tdlm_out_if.source led
);

    // Input stage.
    logic                s1_valid_reg;
    logic [NUMBER_W-1:0] s1_number_reg;
    logic [POS_W-1:0]    s1_position_reg;

    // Result stage.
    logic                s2_valid_reg;
    logic                s2_lit_reg;
    logic [LEVEL_W-1:0]  s2_level_reg;

    logic [LEVEL_W-1:0]  pixel_level_reg;

    logic                s2_load;
    logic                s1_load;
    logic                glyph_lit;

    // The result register can take a new value when it is empty or being drained.
    assign s2_load = !s2_valid_reg || led.ready;
    // The input register can take a new request when it is empty or passing its item on.
    assign s1_load = !s1_valid_reg || s2_load;

    assign number_pos.ready = s1_load;
    assign cfg.ready        = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_level_reg <= LEVEL_RESET;
        end
        else if (cfg.valid)
        begin
            pixel_level_reg <= cfg.pixel_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= number_pos.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && number_pos.valid)
        begin
            s1_number_reg   <= number_pos.shown_number;
            s1_position_reg <= number_pos.strip_position;
        end
    end

    tdlm_glyph u_glyph (
        .shown_number   (s1_number_reg),
        .strip_position (s1_position_reg),
        .lit            (glyph_lit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Dark LEDs send zero on every colour; lit ones send the configured level.
    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_lit_reg   <= glyph_lit;
            s2_level_reg <= glyph_lit ? pixel_level_reg : '0;
        end
    end

    assign led.valid      = s2_valid_reg;
    assign led.lit        = s2_lit_reg;
    assign led.green_byte = s2_level_reg;
    assign led.blue_byte  = s2_level_reg;
    assign led.red_byte   = s2_level_reg;

endmodule

`default_nettype wire
